/* rtl/jsu_pkg.sv */
// Shared types, codes and helper functions for the JSON string unescaper.
package jsu_pkg;

    // Input transaction: one raw byte of the string body or an end marker
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } item_t;

    // Result transaction: one decoded byte, an end mark or an error
    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] result_kind;
        logic [2:0] error_code;
        logic       last;
    } result_t;

    localparam int unsigned MaxResults = 4;
    localparam int unsigned CountW     = $clog2(MaxResults + 1);

    // Results produced by one input byte, first result in slot 0
    typedef struct packed {
        logic [CountW-1:0]           count;
        result_t [MaxResults-1:0]    slot;
    } dec_out_t;

    // UTF-8 encoding of one code point
    typedef struct packed {
        logic [CountW-1:0]       count;
        logic [3:0][7:0]         bytes;
    } utf8_t;

    // Decoder modes, one-hot
    typedef enum logic [5:0] {
        MODE_NORMAL  = 6'b000001,
        MODE_ESCAPE  = 6'b000010,
        MODE_HEX_HI  = 6'b000100,
        MODE_WANT_BS = 6'b001000,
        MODE_WANT_U  = 6'b010000,
        MODE_HEX_LO  = 6'b100000
    } mode_t;

    // Result kinds
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_ESCAPE     = 3'd1;
    localparam logic [2:0] ERR_HEX        = 3'd2;
    localparam logic [2:0] ERR_INCOMPLETE = 3'd3;
    localparam logic [2:0] ERR_BAD_LOW    = 3'd4;
    localparam logic [2:0] ERR_LONE_LOW   = 3'd5;
    localparam logic [2:0] ERR_UNTERM     = 3'd6;

    // Characters of interest
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    localparam logic [7:0] CTL_BS  = 8'h08;
    localparam logic [7:0] CTL_FF  = 8'h0C;
    localparam logic [7:0] CTL_LF  = 8'h0A;
    localparam logic [7:0] CTL_CR  = 8'h0D;
    localparam logic [7:0] CTL_TAB = 8'h09;

    // Surrogate ranges by their top six bits, and the supplementary plane base
    localparam logic [5:0]  SURR_HIGH_TAG = 6'b110110;
    localparam logic [5:0]  SURR_LOW_TAG  = 6'b110111;
    localparam logic [20:0] SUPP_BASE     = 21'h10000;

    // Hex digit value in the low four bits; bit four flags a non-hex byte
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] d;
        if (c inside {[8'h30:8'h39]}) begin
            d = {1'b0, c[3:0]};
        end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            d = {1'b0, c[3:0] + 4'd9};
        end else begin
            d = 5'h10;
        end
        return d;
    endfunction

    // Encode a code point as one to four UTF-8 bytes
    function automatic utf8_t utf8_encode(input logic [20:0] cp);
        utf8_t u;
        u.bytes = '0;
        if (cp[20:7] == '0) begin
            u.count    = CountW'(1);
            u.bytes[0] = cp[7:0];
        end else if (cp[20:11] == '0) begin
            u.count    = CountW'(2);
            u.bytes[0] = {3'b110, cp[10:6]};
            u.bytes[1] = {2'b10, cp[5:0]};
        end else if (cp[20:16] == '0) begin
            u.count    = CountW'(3);
            u.bytes[0] = {4'b1110, cp[15:12]};
            u.bytes[1] = {2'b10, cp[11:6]};
            u.bytes[2] = {2'b10, cp[5:0]};
        end else begin
            u.count    = CountW'(4);
            u.bytes[0] = {5'b11110, cp[20:18]};
            u.bytes[1] = {2'b10, cp[17:12]};
            u.bytes[2] = {2'b10, cp[11:6]};
            u.bytes[3] = {2'b10, cp[5:0]};
        end
        return u;
    endfunction

endpackage

/* rtl/json_string_unescaper.sv */
// Top level of the JSON string unescaper: input register, decoder and result buffer.
//
// Takes the bytes of a JSON string body one per transaction and returns the decoded
// UTF-8 bytes, end marks and error codes, one result per transaction. A byte is
// registered, decoded in one pass and its results (zero to four) are loaded together
// into the result buffer, which drains one per cycle unless the output stalls. Input bytes
// are accepted every cycle as long as each makes at most one result and the output does
// not stall; a byte that makes more results holds the input until the buffer can load.
// Backslashes and partial escapes make no result and never wait on the output.
// The first result of a byte appears after the input register and the result buffer.
module json_string_unescaper import jsu_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    logic     in_valid_reg, in_valid_next;
    item_t    in_reg;
    logic     accept;
    logic     consume;
    logic     load;
    logic     can_load;
    dec_out_t dec;

    // Consume the held byte when its results fit into the buffer
    assign consume    = in_valid_reg && ((dec.count == '0) || can_load);
    assign load       = consume && (dec.count != '0);
    assign item_stall = in_valid_reg && !consume;
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept) begin
            in_valid_next = 1'b1;
        end else if (consume) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Capture the incoming transaction
    always_ff @(posedge clk)
    begin
        if (accept) begin
            in_reg <= item;
        end
    end

    jsu_dec u_dec (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (in_reg),
        .advance (consume),
        .dec     (dec)
    );

    jsu_obuf u_obuf (
        .clk          (clk),
        .rst_n        (rst_n),
        .dec          (dec),
        .load         (load),
        .can_load     (can_load),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // An empty input register never stalls the source
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> !item_stall)
        else $error("stall with empty input register");

    // A loaded group appears at the output in the next cycle
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> result_valid)
        else $error("loaded results not visible");

    // A held byte that makes no result is always consumed at once
    a_silent_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && dec.count == '0) |-> consume)
        else $error("silent byte was held");

endmodule

/* rtl/jsu_dec.sv */
// Escape decoder: mode and hex state registers plus single-pass decode logic.
module jsu_dec import jsu_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  item_t    item,
    input  logic     advance,
    output dec_out_t dec
);

    mode_t       mode_reg,  mode_next;
    logic [15:0] hex_reg,   hex_next;
    logic [1:0]  digits_reg, digits_next;
    logic [9:0]  high_reg,  high_next;

    logic [7:0]  c;
    logic [4:0]  d;
    logic [15:0] val;
    logic [20:0] pair_cp;
    logic [20:0] cp;
    logic        emit;
    utf8_t       u;
    logic [3:0][7:0] bytes;
    logic [CountW-1:0] n;
    logic [1:0]  kind;
    logic [2:0]  code;
    logic        clear;

    assign c       = item.in_byte;
    assign d       = hex_digit(c);
    assign val     = {hex_reg[11:0], d[3:0]};
    assign pair_cp = SUPP_BASE + {1'b0, high_reg, val[9:0]};
    assign u       = utf8_encode(cp);

    // Decode the held byte against the current mode
    always_comb
    begin
        mode_next   = mode_reg;
        hex_next    = hex_reg;
        digits_next = digits_reg;
        high_next   = high_reg;
        n           = '0;
        bytes       = '0;
        kind        = KIND_DATA;
        code        = ERR_NONE;
        cp          = '0;
        emit        = 1'b0;
        clear       = 1'b0;

        if (item.end_of_input) begin
            kind  = KIND_ERR;
            n     = CountW'(1);
            clear = 1'b1;
            if (mode_reg == MODE_WANT_BS || mode_reg == MODE_WANT_U ||
                mode_reg == MODE_HEX_LO) begin
                code = ERR_INCOMPLETE;
            end else begin
                code = ERR_UNTERM;
            end
        end else begin
            case (mode_reg)
                MODE_ESCAPE:
                begin
                    mode_next = MODE_NORMAL;
                    n         = CountW'(1);
                    case (c)
                        CH_QUOTE:  bytes[0] = CH_QUOTE;
                        CH_BSLASH: bytes[0] = CH_BSLASH;
                        CH_SLASH:  bytes[0] = CH_SLASH;
                        CH_B:      bytes[0] = CTL_BS;
                        CH_F:      bytes[0] = CTL_FF;
                        CH_N:      bytes[0] = CTL_LF;
                        CH_R:      bytes[0] = CTL_CR;
                        CH_T:      bytes[0] = CTL_TAB;
                        CH_U:
                        begin
                            n           = '0;
                            mode_next   = MODE_HEX_HI;
                            hex_next    = '0;
                            digits_next = '0;
                        end
                        default:
                        begin
                            kind  = KIND_ERR;
                            code  = ERR_ESCAPE;
                            clear = 1'b1;
                        end
                    endcase
                end
                MODE_HEX_HI, MODE_HEX_LO:
                begin
                    if (d[4]) begin
                        kind  = KIND_ERR;
                        code  = ERR_HEX;
                        n     = CountW'(1);
                        clear = 1'b1;
                    end else if (digits_reg != 2'd3) begin
                        hex_next    = val;
                        digits_next = digits_reg + 2'd1;
                    end else if (mode_reg == MODE_HEX_HI) begin
                        if (val[15:10] == SURR_HIGH_TAG) begin
                            high_next   = val[9:0];
                            mode_next   = MODE_WANT_BS;
                            hex_next    = '0;
                            digits_next = '0;
                        end else if (val[15:10] == SURR_LOW_TAG) begin
                            kind  = KIND_ERR;
                            code  = ERR_LONE_LOW;
                            n     = CountW'(1);
                            clear = 1'b1;
                        end else begin
                            cp    = {5'd0, val};
                            emit  = 1'b1;
                            clear = 1'b1;
                        end
                    end else begin
                        if (val[15:10] == SURR_LOW_TAG) begin
                            cp    = pair_cp;
                            emit  = 1'b1;
                            clear = 1'b1;
                        end else begin
                            kind  = KIND_ERR;
                            code  = ERR_BAD_LOW;
                            n     = CountW'(1);
                            clear = 1'b1;
                        end
                    end
                end
                MODE_WANT_BS:
                begin
                    if (c == CH_BSLASH) begin
                        mode_next = MODE_WANT_U;
                    end else begin
                        kind  = KIND_ERR;
                        code  = ERR_INCOMPLETE;
                        n     = CountW'(1);
                        clear = 1'b1;
                    end
                end
                MODE_WANT_U:
                begin
                    if (c == CH_U) begin
                        mode_next   = MODE_HEX_LO;
                        hex_next    = '0;
                        digits_next = '0;
                    end else begin
                        kind  = KIND_ERR;
                        code  = ERR_INCOMPLETE;
                        n     = CountW'(1);
                        clear = 1'b1;
                    end
                end
                default:
                begin
                    mode_next = MODE_NORMAL;
                    if (c == CH_QUOTE) begin
                        kind = KIND_END;
                        n    = CountW'(1);
                    end else if (c == CH_BSLASH) begin
                        mode_next = MODE_ESCAPE;
                    end else begin
                        bytes[0] = c;
                        n        = CountW'(1);
                    end
                end
            endcase
        end

        if (emit) begin
            bytes = u.bytes;
            n     = u.count;
        end

        if (clear) begin
            mode_next   = MODE_NORMAL;
            hex_next    = '0;
            digits_next = '0;
            high_next   = '0;
        end
    end

    // Pack the results; only data results carry a byte
    always_comb
    begin
        dec.count = n;
        for (int i = 0; i < MaxResults; i++) begin
            dec.slot[i].out_byte    = (kind == KIND_DATA) ? bytes[i] : 8'h00;
            dec.slot[i].result_kind = kind;
            dec.slot[i].error_code  = code;
            dec.slot[i].last        = (CountW'(i + 1) == n);
        end
    end

    // Advance state when the held byte is consumed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg   <= MODE_NORMAL;
            hex_reg    <= '0;
            digits_reg <= '0;
            high_reg   <= '0;
        end else if (advance) begin
            mode_reg   <= mode_next;
            hex_reg    <= hex_next;
            digits_reg <= digits_next;
            high_reg   <= high_next;
        end
    end

endmodule

/* rtl/jsu_obuf.sv */
// Result buffer: holds the results of one byte and drains them one per cycle unless stalled.
module jsu_obuf import jsu_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  dec_out_t dec,
    input  logic     load,
    output logic     can_load,
    output logic     result_valid,
    input  logic     result_stall,
    output result_t  result
);

    logic [CountW-1:0]        cnt_reg, cnt_next;
    result_t [MaxResults-1:0] slot_reg, slot_next;
    logic                     pop;

    assign result_valid = (cnt_reg != '0);
    assign result       = slot_reg[0];
    assign pop          = result_valid && !result_stall;
    assign can_load     = (cnt_reg == '0) || (cnt_reg == CountW'(1) && pop);

    // Load a fresh group, or shift the next result to the head
    always_comb
    begin
        cnt_next  = cnt_reg;
        slot_next = slot_reg;
        if (load) begin
            cnt_next  = dec.count;
            slot_next = dec.slot;
        end else if (pop) begin
            cnt_next = cnt_reg - CountW'(1);
            for (int i = 0; i < MaxResults - 1; i++) begin
                slot_next[i] = slot_reg[i + 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    // Count never exceeds the group size
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CountW'(MaxResults))
        else $error("result count out of range");

    // A stalled head result holds the count
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall && !load) |=> (cnt_reg == $past(cnt_reg)))
        else $error("count moved under stall");

    // The head result is marked last exactly when it is the only one left
    a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.last == (cnt_reg == CountW'(1))))
        else $error("last flag disagrees with remaining count");

endmodule
